[hw/rtl/lap27_pkg.sv]
// ----------------------------------------------------------------------------
// lap27_pkg
// Shared types, constants and the entry slot table for the 27-point stencil
// Laplacian column generator.
// ----------------------------------------------------------------------------
package lap27_pkg;

  // Default grid extent limit
  localparam int MAX_DIM = 1024;

  // Fixed field widths
  localparam int SIZE_W     = 11;
  localparam int PLANE_W    = 10;
  localparam int COEF_W     = 32;
  localparam int IDX_W      = 30;
  localparam int POS_W      = 34;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NSLOT      = 14;
  localparam int SLOT_W     = 4;
  localparam int DEG_W      = 5;

  // Q0.32 reciprocals of sqrt(2) and sqrt(3)
  localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;
  localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700524;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_FIRST  = 3'd0,
    REG_SIZE_SECOND = 3'd1,
    REG_SIZE_THIRD  = 3'd2,
    REG_FIRST_PLANE = 3'd3,
    REG_END_PLANE   = 3'd4,
    REG_ALPHA_COEF  = 3'd5,
    REG_BETA_COEF   = 3'd6
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_PREP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic check;
    logic mul1;
    logic mul2;
    logic mul3;
    logic prep;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slab_ok;
    logic emit_done;
  } status_t;

  // Row base of an entry slot
  typedef enum logic [2:0] {
    BASE_L,
    BASE_LS,
    BASE_PM,
    BASE_P,
    BASE_PP
  } base_t;

  // Offset along the fastest dimension
  typedef enum logic [1:0] {
    OFF_M1,
    OFF_0,
    OFF_P1
  } off_t;

  // Value class of an entry slot
  typedef enum logic [1:0] {
    VAL_DIAG,
    VAL_B,
    VAL_G,
    VAL_D
  } val_t;

  typedef struct packed {
    base_t base;
    off_t  off;
    val_t  val;
  } slot_t;

  // Slot table, in ascending row order
  function automatic slot_t slot_info(input logic [SLOT_W-1:0] s);
    slot_t r;
    r = '{base: BASE_L, off: OFF_0, val: VAL_DIAG};
    unique case (s)
      4'd0:    r = '{base: BASE_L,  off: OFF_0,  val: VAL_DIAG};
      4'd1:    r = '{base: BASE_L,  off: OFF_P1, val: VAL_B};
      4'd2:    r = '{base: BASE_LS, off: OFF_M1, val: VAL_G};
      4'd3:    r = '{base: BASE_LS, off: OFF_0,  val: VAL_B};
      4'd4:    r = '{base: BASE_LS, off: OFF_P1, val: VAL_G};
      4'd5:    r = '{base: BASE_PM, off: OFF_M1, val: VAL_D};
      4'd6:    r = '{base: BASE_PM, off: OFF_0,  val: VAL_G};
      4'd7:    r = '{base: BASE_PM, off: OFF_P1, val: VAL_D};
      4'd8:    r = '{base: BASE_P,  off: OFF_M1, val: VAL_G};
      4'd9:    r = '{base: BASE_P,  off: OFF_0,  val: VAL_B};
      4'd10:   r = '{base: BASE_P,  off: OFF_P1, val: VAL_G};
      4'd11:   r = '{base: BASE_PP, off: OFF_M1, val: VAL_D};
      4'd12:   r = '{base: BASE_PP, off: OFF_0,  val: VAL_G};
      4'd13:   r = '{base: BASE_PP, off: OFF_P1, val: VAL_D};
      default: r = '{base: BASE_L,  off: OFF_0,  val: VAL_DIAG};
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/lap27_ctrl.sv]
// ----------------------------------------------------------------------------
// lap27_ctrl
// Sequencer: takes a request word, steps the datapath through the slab
// check, the multiply stages and prep, then drains the column entries.
// ----------------------------------------------------------------------------
module lap27_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lap27_pkg::status_t status,
  output lap27_pkg::cmd_t    cmd
);

  lap27_pkg::state_t state;
  lap27_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lap27_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lap27_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = lap27_pkg::ST_CHECK;
        end
      end
      lap27_pkg::ST_CHECK: begin
        state_next = status.slab_ok ? lap27_pkg::ST_MUL1 : lap27_pkg::ST_IDLE;
      end
      lap27_pkg::ST_MUL1: state_next = lap27_pkg::ST_MUL2;
      lap27_pkg::ST_MUL2: state_next = lap27_pkg::ST_MUL3;
      lap27_pkg::ST_MUL3: state_next = lap27_pkg::ST_PREP;
      lap27_pkg::ST_PREP: state_next = lap27_pkg::ST_EMIT;
      lap27_pkg::ST_EMIT: begin
        if (status.emit_done) begin
          state_next = lap27_pkg::ST_IDLE;
        end
      end
      default: state_next = lap27_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      lap27_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      lap27_pkg::ST_CHECK: cmd.check = 1'b1;
      lap27_pkg::ST_MUL1:  cmd.mul1  = 1'b1;
      lap27_pkg::ST_MUL2:  cmd.mul2  = 1'b1;
      lap27_pkg::ST_MUL3:  cmd.mul3  = 1'b1;
      lap27_pkg::ST_PREP:  cmd.prep  = 1'b1;
      lap27_pkg::ST_EMIT:  cmd.emit  = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

[hw/rtl/lap27_datapath.sv]
// ----------------------------------------------------------------------------
// lap27_datapath
// Configuration registers, slab walk counters, index and coefficient
// arithmetic, entry slot selection and the output register.
// ----------------------------------------------------------------------------
module lap27_datapath #(
  parameter int MAX_DIM = lap27_pkg::MAX_DIM
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [lap27_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lap27_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    restart,
  input  lap27_pkg::cmd_t                         cmd,
  output lap27_pkg::status_t                      status,
  input  logic                                    out_ready,
  output logic                                    out_valid,
  output logic [lap27_pkg::IDX_W-1:0]             row_index,
  output logic signed [lap27_pkg::COEF_W-1:0]     entry_value,
  output logic [lap27_pkg::IDX_W-1:0]             column_index,
  output logic [lap27_pkg::POS_W-1:0]             entry_position,
  output logic                                    last_in_column,
  output logic                                    last_column
);

  localparam int SIZE_W = lap27_pkg::SIZE_W;
  localparam int IW     = lap27_pkg::IDX_W;
  localparam int NSLOT  = lap27_pkg::NSLOT;
  localparam int SLOT_W = lap27_pkg::SLOT_W;
  localparam int DEG_W  = lap27_pkg::DEG_W;
  localparam int SW     = $clog2(MAX_DIM + 1);
  localparam int PW     = $clog2(MAX_DIM + 1);
  localparam int RW     = $clog2(MAX_DIM);
  localparam int CW     = (SIZE_W > SW + 1) ? SIZE_W : SW + 1;
  localparam int DPW    = DEG_W + lap27_pkg::COEF_W + 1;

  // Configuration registers
  logic [SIZE_W-1:0]                 size_first;
  logic [SIZE_W-1:0]                 size_second;
  logic [SIZE_W-1:0]                 size_third;
  logic [lap27_pkg::PLANE_W-1:0]     first_plane;
  logic [SIZE_W-1:0]                 end_plane;
  logic signed [lap27_pkg::COEF_W-1:0] alpha_coef;
  logic [lap27_pkg::COEF_W-1:0]      beta_coef;

  // Walk counters
  logic [PW-1:0]                     plane_pos;
  logic [RW-1:0]                     row_pos;
  logic [RW-1:0]                     col_pos;
  logic [lap27_pkg::POS_W-1:0]       entry_count;

  // Per-column registers
  logic                              j_lo, j_hi, i_lo, i_hi, k_hi;
  logic                              col_last;
  logic [DEG_W-1:0]                  deg;
  logic signed [DEG_W+lap27_pkg::COEF_W:0] diag_prod;
  logic [31:0]                       diag;
  logic [63:0]                       vg_prod, vd_prod;
  logic [31:0]                       vg, vd;
  logic [IW-1:0]                     kprod, lprod, ss, ssm, ssp;
  logic [IW-1:0]                     gcol, base_ls, base_p, base_pm, base_pp;
  logic [NSLOT-1:0]                  mask;

  // Combinational terms
  logic [SW-1:0]                     s1c, s2c, s3c;
  logic [CW-1:0]                     epx, fpx, kx, ix, jx, s1x, s2x, s3x;
  logic                              kl, kh, il, ih, jl, jh;
  logic [1:0]                        dk, di, dj;
  logic [31:0]                       beta_mag, kconst;
  logic [63:0]                       sc_prod, vg_sum, vd_sum;
  logic [IW-1:0]                     kpi;
  logic [IW+SW-1:0]                  lprod_full;
  logic [PW+SW-1:0]                  kprod_full;
  logic [2*SW-1:0]                   ss_full;
  logic [RW:0]                       j_inc, i_inc;
  logic [NSLOT-1:0]                  mask_rest;
  logic [SLOT_W-1:0]                 sel;
  lap27_pkg::slot_t                  slot;
  logic [IW-1:0]                     row_base, row_off, row_sel;
  logic [31:0]                       val_sel;
  logic                              out_free, load;

  function automatic logic [SW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve == '0) begin
      return SW'(1);
    end else if (ve > CW'(MAX_DIM)) begin
      return SW'(MAX_DIM);
    end
    return SW'(ve);
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_first  <= SIZE_W'(1);
      size_second <= SIZE_W'(1);
      size_third  <= SIZE_W'(1);
      first_plane <= '0;
      end_plane   <= SIZE_W'(1);
      alpha_coef  <= 32'sd65536;
      beta_coef   <= 32'd65536;
    end else if (cfg_write) begin
      unique case (lap27_pkg::cfg_reg_t'(cfg_index))
        lap27_pkg::REG_SIZE_FIRST:  size_first  <= cfg_data[SIZE_W-1:0];
        lap27_pkg::REG_SIZE_SECOND: size_second <= cfg_data[SIZE_W-1:0];
        lap27_pkg::REG_SIZE_THIRD:  size_third  <= cfg_data[SIZE_W-1:0];
        lap27_pkg::REG_FIRST_PLANE: first_plane <= cfg_data[lap27_pkg::PLANE_W-1:0];
        lap27_pkg::REG_END_PLANE:   end_plane   <= cfg_data[SIZE_W-1:0];
        lap27_pkg::REG_ALPHA_COEF:  alpha_coef  <= $signed(cfg_data);
        lap27_pkg::REG_BETA_COEF:   beta_coef   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes and slab bounds
  always_comb begin
    s1c = clamp_size(size_first);
    s2c = clamp_size(size_second);
    s3c = clamp_size(size_third);
    s1x = CW'(s1c);
    s2x = CW'(s2c);
    s3x = CW'(s3c);
    epx = (CW'(end_plane) < s1x) ? CW'(end_plane) : s1x;
    fpx = CW'(first_plane);
    kx  = CW'(plane_pos);
    ix  = CW'(row_pos);
    jx  = CW'(col_pos);
    status.slab_ok = (fpx < epx) && (kx >= fpx) && (kx < epx) &&
                     (ix < s2x) && (jx < s3x);
    // drain ends once the last pending slot is loaded
    status.emit_done = out_free & (mask_rest == '0);
    kl = (kx != '0);
    kh = (kx < s1x - CW'(1));
    il = (ix != '0);
    ih = (ix < s2x - CW'(1));
    jl = (jx != '0);
    jh = (jx < s3x - CW'(1));
    dk = 2'd1 + {1'b0, kl} + {1'b0, kh};
    di = 2'd1 + {1'b0, il} + {1'b0, ih};
    dj = 2'd1 + {1'b0, jl} + {1'b0, jh};
  end

  // Shared coefficient multiplier and index products
  assign beta_mag   = beta_coef[31] ? (~beta_coef + 32'd1) : beta_coef;
  assign kconst     = cmd.mul1 ? lap27_pkg::INV_SQRT2_Q32 : lap27_pkg::INV_SQRT3_Q32;
  assign sc_prod    = 64'(beta_mag) * 64'(kconst);
  assign kprod_full = (PW+SW)'(plane_pos) * (PW+SW)'(s2c);
  assign kpi        = kprod + IW'(row_pos);
  assign lprod_full = (IW+SW)'(kpi) * (IW+SW)'(s3c);
  assign ss_full    = (2*SW)'(s2c) * (2*SW)'(s3c);
  assign vg_sum     = vg_prod + 64'h0000_0000_8000_0000;
  assign vd_sum     = vd_prod + 64'h0000_0000_8000_0000;

  // Column set-up pipeline
  always_ff @(posedge clk) begin
    if (cmd.check) begin
      j_lo     <= jl;
      j_hi     <= jh;
      i_lo     <= il;
      i_hi     <= ih;
      k_hi     <= kh;
      col_last <= (kx == epx - CW'(1)) && (ix == s2x - CW'(1)) && (jx == s3x - CW'(1));
      deg      <= ({3'b0, dk} * {3'b0, di} * {3'b0, dj}) - DEG_W'(1);
    end
    if (cmd.mul1) begin
      diag_prod <= DPW'($signed({1'b0, deg})) * DPW'(alpha_coef);
      vg_prod   <= sc_prod;
      kprod     <= IW'(kprod_full);
    end
    if (cmd.mul2) begin
      if (diag_prod[DEG_W+lap27_pkg::COEF_W:31] == '0 ||
          diag_prod[DEG_W+lap27_pkg::COEF_W:31] == '1) begin
        diag <= diag_prod[31:0];
      end else begin
        diag <= diag_prod[DEG_W+lap27_pkg::COEF_W] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      vd_prod <= sc_prod;
      lprod   <= IW'(lprod_full);
      ss      <= IW'(ss_full);
    end
    if (cmd.mul3) begin
      gcol <= lprod + IW'(col_pos);
      ssm  <= ss - IW'(s3c);
      ssp  <= ss + IW'(s3c);
      vg   <= beta_coef[31] ? (32'd0 - vg_sum[63:32]) : vg_sum[63:32];
      vd   <= beta_coef[31] ? (32'd0 - vd_sum[63:32]) : vd_sum[63:32];
    end
    if (cmd.prep) begin
      base_ls <= gcol + IW'(s3c);
      base_p  <= gcol + ss;
      base_pm <= gcol + ssm;
      base_pp <= gcol + ssp;
    end
  end

  // Slot mask: build on prep, drop the emitted slot on each load
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.prep) begin
      mask[0]  <= 1'b1;
      mask[1]  <= j_hi;
      mask[2]  <= i_hi & j_lo;
      mask[3]  <= i_hi;
      mask[4]  <= i_hi & j_hi;
      mask[5]  <= k_hi & i_lo & j_lo;
      mask[6]  <= k_hi & i_lo;
      mask[7]  <= k_hi & i_lo & j_hi;
      mask[8]  <= k_hi & j_lo;
      mask[9]  <= k_hi;
      mask[10] <= k_hi & j_hi;
      mask[11] <= k_hi & i_hi & j_lo;
      mask[12] <= k_hi & i_hi;
      mask[13] <= k_hi & i_hi & j_hi;
    end else if (load) begin
      mask <= mask_rest;
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    sel = '0;
    for (int s = NSLOT - 1; s >= 0; s--) begin
      if (mask[s]) begin
        sel = SLOT_W'(s);
      end
    end
  end

  assign mask_rest = mask & (mask - NSLOT'(1));
  assign slot      = lap27_pkg::slot_info(sel);

  // Row and value of the selected slot
  always_comb begin
    unique case (slot.base)
      lap27_pkg::BASE_L:  row_base = gcol;
      lap27_pkg::BASE_LS: row_base = base_ls;
      lap27_pkg::BASE_PM: row_base = base_pm;
      lap27_pkg::BASE_P:  row_base = base_p;
      lap27_pkg::BASE_PP: row_base = base_pp;
      default:            row_base = gcol;
    endcase
    unique case (slot.off)
      lap27_pkg::OFF_M1: row_off = '1;
      lap27_pkg::OFF_P1: row_off = IW'(1);
      default:           row_off = '0;
    endcase
    row_sel = row_base + row_off;
    unique case (slot.val)
      lap27_pkg::VAL_DIAG: val_sel = diag;
      lap27_pkg::VAL_B:    val_sel = beta_coef;
      lap27_pkg::VAL_G:    val_sel = vg;
      lap27_pkg::VAL_D:    val_sel = vd;
      default:             val_sel = diag;
    endcase
  end

  assign out_free         = ~out_valid | out_ready;
  assign load             = cmd.emit & out_free;

  // Walk counters: restart on a request with restart set, advance once per emitted column
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_pos   <= '0;
      row_pos     <= '0;
      col_pos     <= '0;
      entry_count <= '0;
    end else begin
      if (cmd.accept && restart) begin
        plane_pos   <= PW'(first_plane);
        row_pos     <= '0;
        col_pos     <= '0;
        entry_count <= '0;
      end else if (load) begin
        entry_count <= entry_count + lap27_pkg::POS_W'(1);
      end
      if (cmd.prep) begin
        if (CW'(j_inc) >= s3x) begin
          col_pos <= '0;
          if (CW'(i_inc) >= s2x) begin
            row_pos   <= '0;
            plane_pos <= plane_pos + PW'(1);
          end else begin
            row_pos <= RW'(i_inc);
          end
        end else begin
          col_pos <= RW'(j_inc);
        end
      end
    end
  end

  assign j_inc = {1'b0, col_pos} + (RW + 1)'(1);
  assign i_inc = {1'b0, row_pos} + (RW + 1)'(1);

  // Output register: hold while stalled, load the next word when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_index      <= row_sel;
      entry_value    <= $signed(val_sel);
      column_index   <= gcol;
      entry_position <= entry_count;
      last_in_column <= (mask_rest == '0);
      last_column    <= col_last;
    end
  end

endmodule

[hw/rtl/laplacian_27pt_csc_generator_core.sv]
// ----------------------------------------------------------------------------
// laplacian_27pt_csc_generator_core
// Emits the lower-triangular CSC entries of a 3D 27-point stencil Laplacian,
// one column of the local slab per request word.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   request  | in_valid / in_ready    | restart
//   entry    | out_valid / out_ready  | row_index, entry_value, column_index,
//            |                        | entry_position, last_in_column,
//            |                        | last_column
//   config   | cfg_write              | cfg_index, cfg_data
//
// A column with n entries (1 to 14) goes through an accept step, a slab check,
// four set-up steps (mul1 and mul2 on the shared multiplier, then mul3, prep)
// and one entry a cycle out of the output register while out_ready allows,
// before the next request is taken. Out-of-slab requests emit nothing.
// Synchronous reset puts the walk at plane 0 with the default registers.
// A low out_ready holds the sequencer in the entry drain.
// ----------------------------------------------------------------------------
module laplacian_27pt_csc_generator_core #(
  parameter int MAX_DIM = lap27_pkg::MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lap27_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lap27_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lap27_pkg::IDX_W-1:0]         row_index,
  output logic signed [lap27_pkg::COEF_W-1:0] entry_value,
  output logic [lap27_pkg::IDX_W-1:0]         column_index,
  output logic [lap27_pkg::POS_W-1:0]         entry_position,
  output logic                                last_in_column,
  output logic                                last_column
);

  lap27_pkg::cmd_t    cmd;
  lap27_pkg::status_t status;

  // Sequencer
  lap27_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, counters and output register
  lap27_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .restart        (restart),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .row_index      (row_index),
    .entry_value    (entry_value),
    .column_index   (column_index),
    .entry_position (entry_position),
    .last_in_column (last_in_column),
    .last_column    (last_column)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 27-point stencil Laplacian column generator.
// A scoreboard walks the slab alongside the block, predicts every CSC entry
// of each requested column and compares the entry stream field by field,
// across many grid setups and under random idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import lap27_pkg::*;

  localparam int COLUMN_TARGET = 410;
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 24;

  // One CSC entry as seen on the output channel
  typedef struct {
    bit [IDX_W-1:0]         row;
    bit signed [COEF_W-1:0] value;
    bit [IDX_W-1:0]         col;
    bit [POS_W-1:0]         pos;
    bit                     col_end;
    bit                     slab_end;
  } entry_t;

  // Walks the slab and keeps the entries still owed by the block
  class column_scoreboard;
    bit [SIZE_W-1:0]        size_first, size_second, size_third, end_plane;
    bit [PLANE_W-1:0]       first_plane;
    bit signed [COEF_W-1:0] alpha, beta;
    bit [SIZE_W-1:0]        plane_pos;
    bit [PLANE_W-1:0]       row_pos, col_pos;
    bit [IDX_W-1:0]         global_col;
    bit [POS_W-1:0]         entry_count;
    longint                 cur_col;
    bit                     cur_last;
    entry_t                 pending_entries[$];
    int                     errors, columns, entries_checked, restarts;

    function new();
      size_first  = 1;
      size_second = 1;
      size_third  = 1;
      end_plane   = 1;
      alpha       = 65536;
      beta        = 65536;
    endfunction

    function longint eff_dim(bit [SIZE_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] d);
      case (idx)
        REG_SIZE_FIRST:  size_first  = d[SIZE_W-1:0];
        REG_SIZE_SECOND: size_second = d[SIZE_W-1:0];
        REG_SIZE_THIRD:  size_third  = d[SIZE_W-1:0];
        REG_FIRST_PLANE: first_plane = d[PLANE_W-1:0];
        REG_END_PLANE:   end_plane   = d[SIZE_W-1:0];
        REG_ALPHA_COEF:  alpha       = d;
        REG_BETA_COEF:   beta        = d;
        default: ;
      endcase
    endfunction

    // |b| times a Q0.32 constant, rounded half away from zero, sign restored
    function longint scaled(longint b, bit [63:0] k);
      bit [63:0] mag, r;
      mag = (b < 0) ? -b : b;
      r = (mag * k + 64'd2147483648) >> 32;
      return (b < 0) ? -longint'(r) : longint'(r);
    endfunction

    function void add_entry(longint r, longint v);
      entry_t e;
      e.row      = r[IDX_W-1:0];
      e.value    = v[COEF_W-1:0];
      e.col      = cur_col[IDX_W-1:0];
      e.pos      = entry_count;
      e.col_end  = 1'b0;
      e.slab_end = cur_last;
      pending_entries.push_back(e);
      entry_count++;
    endfunction

    // centre entry with its neighbours one step either way along the fastest axis
    function void add_run(longint r, bit lo, bit hi, longint vc, longint vs);
      if (lo) add_entry(r - 1, vs);
      add_entry(r, vc);
      if (hi) add_entry(r + 1, vs);
    endfunction

    // Predict the column that one accepted request word produces
    function void note_request(bit rs);
      longint s1, s2, s3, fp, ep, k, i, j, l, pl, diag, vb, vg, vd;
      int     dk, di, dj;
      bit     jl, jh;
      s1 = eff_dim(size_first);
      s2 = eff_dim(size_second);
      s3 = eff_dim(size_third);
      fp = first_plane;
      ep = (end_plane < s1) ? end_plane : s1;
      if (rs) begin
        plane_pos   = first_plane;
        row_pos     = '0;
        col_pos     = '0;
        global_col  = fp * s2 * s3;
        entry_count = '0;
        restarts++;
      end
      k = plane_pos;
      i = row_pos;
      j = col_pos;
      // walk finished, empty slab or counters outside the grid: nothing owed
      if (fp >= ep || k < fp || k >= ep || i >= s2 || j >= s3) return;

      l = (k * s2 + i) * s3 + j;
      global_col = l;
      cur_col    = l;
      cur_last   = (k == ep - 1) && (i == s2 - 1) && (j == s3 - 1);

      // diagonal: neighbour count times alpha, saturated
      dk = 1 + (k > 0) + (k < s1 - 1);
      di = 1 + (i > 0) + (i < s2 - 1);
      dj = 1 + (j > 0) + (j < s3 - 1);
      diag = longint'(dk * di * dj - 1) * longint'(alpha);
      if (diag > 64'sd2147483647) diag = 64'sd2147483647;
      if (diag < -64'sd2147483648) diag = -64'sd2147483648;

      vb = beta;
      vg = scaled(beta, INV_SQRT2_Q32);
      vd = scaled(beta, INV_SQRT3_Q32);
      jl = j > 0;
      jh = j < s3 - 1;

      // higher neighbours in ascending row order
      add_entry(l, diag);
      if (jh) add_entry(l + 1, vb);
      if (i < s2 - 1) add_run(l + s3, jl, jh, vb, vg);
      if (k < s1 - 1) begin
        pl = l + s3 * s2;
        if (i > 0) add_run(pl - s3, jl, jh, vg, vd);
        add_run(pl, jl, jh, vb, vg);
        if (i < s2 - 1) add_run(pl + s3, jl, jh, vg, vd);
      end
      pending_entries[pending_entries.size() - 1].col_end = 1'b1;
      columns++;

      // advance column, then row, then plane
      j++;
      if (j >= s3) begin
        j = 0;
        i++;
        if (i >= s2) begin
          i = 0;
          k++;
        end
      end
      plane_pos = k;
      row_pos   = i;
      col_pos   = j;
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    // Compare one accepted entry word with the oldest owed entry
    function void check_entry(entry_t got);
      entry_t want;
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected entry, row %0d column %0d, expected none",
                 $time, got.row, got.col);
        errors++;
        return;
      end
      want = pending_entries.pop_front();
      entries_checked++;
      if (got.row != want.row)           report("row_index", want.row, got.row);
      if (got.value != want.value)       report("entry_value", want.value, got.value);
      if (got.col != want.col)           report("column_index", want.col, got.col);
      if (got.pos != want.pos)           report("entry_position", want.pos, got.pos);
      if (got.col_end != want.col_end)   report("last_in_column", want.col_end, got.col_end);
      if (got.slab_end != want.slab_end) report("last_column", want.slab_end, got.slab_end);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    restart = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [IDX_W-1:0]        row_index;
  logic signed [COEF_W-1:0] entry_value;
  logic [IDX_W-1:0]        column_index;
  logic [POS_W-1:0]        entry_position;
  logic                    last_in_column;
  logic                    last_column;

  column_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_given     = 0;
  int hold_left      = 0;
  int setups         = 0;

  laplacian_27pt_csc_generator_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .restart        (restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .row_index      (row_index),
    .entry_value    (entry_value),
    .column_index   (column_index),
    .entry_position (entry_position),
    .last_in_column (last_in_column),
    .last_column    (last_column)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (hold_asked != hold_given) begin
      hold_given++;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    entry_t seen;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(restart);
      if (out_valid && out_ready) begin
        seen.row      = row_index;
        seen.value    = entry_value;
        seen.col      = column_index;
        seen.pos      = entry_position;
        seen.col_end  = last_in_column;
        seen.slab_end = last_column;
        sb.check_entry(seen);
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_setup(input logic [SIZE_W-1:0] s1, s2, s3,
                            input logic [PLANE_W-1:0] fp,
                            input logic [SIZE_W-1:0] ep,
                            input logic [COEF_W-1:0] a, b);
    write_reg(REG_SIZE_FIRST, CFG_DATA_W'(s1));
    write_reg(REG_SIZE_SECOND, CFG_DATA_W'(s2));
    write_reg(REG_SIZE_THIRD, CFG_DATA_W'(s3));
    write_reg(REG_FIRST_PLANE, CFG_DATA_W'(fp));
    write_reg(REG_END_PLANE, CFG_DATA_W'(ep));
    write_reg(REG_ALPHA_COEF, a);
    write_reg(REG_BETA_COEF, b);
    setups++;
  endtask

  // Offer one request word after a random gap; hold it until accepted
  task automatic send_request(input bit rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    restart  = rs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every owed entry, then let the block settle
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_entries.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return COEF_W'(int'($urandom_range(262143)) - 131072);
    endcase
  endfunction

  initial begin
    int                 phase_no;
    int                 items;
    longint             e1, e2, e3, eep, walk;
    logic [SIZE_W-1:0]  s1, s2, s3, ep;
    logic [PLANE_W-1:0] fp;
    bit                 rs;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    // reset registers: a single point, then walk finished, then restart
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);

    // 3x3x3, largest alpha, most negative beta: corners, edges, faces, centre
    drain();
    load_setup(11'd3, 11'd3, 11'd3, 10'd0, 11'd3, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(1'b1);
    repeat (13) send_request(1'b0);

    // sizes above the limit, near the top of a 1024^3 grid, saturating low
    drain();
    load_setup(11'd2047, 11'd1024, 11'd1024, 10'd1022, 11'd2047,
               32'h8000_0000, 32'h7FFF_FFFF);
    send_request(1'b1);
    repeat (2) send_request(1'b0);

    // empty slab: first plane beyond the end plane
    drain();
    load_setup(11'd4, 11'd2, 11'd2, 10'd3, 11'd2, 32'h0001_0000, 32'hFFFF_0000);
    send_request(1'b1);
    send_request(1'b0);

    // zero sizes act as one
    drain();
    load_setup(11'd0, 11'd0, 11'd0, 10'd0, 11'd1, 32'hFFFF_FFFF, 32'h0000_0001);
    send_request(1'b1);

    // random slab walks until enough columns have come out
    phase_no = 0;
    while (sb.columns < COLUMN_TARGET) begin
      drain();
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      if (phase_no == 0) begin
        s1 = 11'd4; s2 = 11'd3; s3 = 11'd3; fp = 10'd0; ep = 11'd4;
      end else if (phase_no % 6 == 5) begin
        // a glimpse of a large grid: only a handful of columns
        s1 = $urandom_range(1, 2047);
        s2 = $urandom_range(0, 2047);
        s3 = $urandom_range(0, 2047);
        fp = $urandom_range(0, sb.eff_dim(s1) - 1);
        ep = $urandom_range(fp + 1, 2047);
      end else begin
        s1 = $urandom_range(1, 5);
        s2 = $urandom_range(1, 4);
        s3 = $urandom_range(1, 4);
        if ($urandom_range(9) == 0) s2 = '0;
        if ($urandom_range(9) == 0) s3 = '0;
        fp = $urandom_range(0, s1 - 1);
        ep = $urandom_range(fp + 1, s1 + 1);
        if ($urandom_range(7) == 0) ep = $urandom_range(0, fp);
      end
      load_setup(s1, s2, s3, fp, ep, pick_coef(), pick_coef());

      e1  = sb.eff_dim(s1);
      e2  = sb.eff_dim(s2);
      e3  = sb.eff_dim(s3);
      eep = (ep < e1) ? ep : e1;
      walk = (eep > fp) ? (eep - fp) * e2 * e3 : 0;
      if (phase_no % 6 == 5) items = 6;
      else items = ((walk > 40) ? 40 : walk) + $urandom_range(0, 2);

      // long receiver hold-off while the sender keeps offering
      if (phase_no == 0) hold_asked++;

      for (int n = 0; n < items; n++) begin
        // sender pause until every owed entry is out
        if (phase_no == 2 && n == items / 2) drain();
        rs = (n == 0) ? ($urandom_range(7) != 0) : ($urandom_range(15) == 0);
        send_request(rs);
      end
      phase_no++;
    end

    // wait for the tail, with a bound
    in_valid = 1'b0;
    for (int w = 0; w < 50000 && sb.pending_entries.size() != 0; w++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending_entries.size() != 0) begin
      $display("%0t: %0d entries never arrived, expected 0 outstanding",
               $time, sb.pending_entries.size());
      sb.errors++;
    end

    $display("covered %0d columns, %0d entries checked, %0d register setups, %0d restarts",
             sb.columns, sb.entries_checked, setups, sb.restarts);
    $display("grids from one point to 1024^3, saturating coefficients, idle and stalls");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
